### design/sha256_stream_hash_assert.svh
// assertion macros for the streaming sha-256 hasher
`ifndef SHA256_STREAM_HASH_ASSERT_SVH
`define SHA256_STREAM_HASH_ASSERT_SVH

// condition holds in the same cycle as its trigger
`define SHS_ASSERT_NOW(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error(msg);

// condition holds in the cycle after its trigger
`define SHS_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error(msg);

`endif

### design/sha256s_pkg.sv
// shared constants, functions and control types of the streaming sha-256 hasher
`default_nettype none

package sha256s_pkg;

  localparam int BLOCK_BYTES = 64;
  localparam int BLOCK_WORDS = 16;
  localparam int WORD_BYTES  = 4;
  localparam int HASH_WORDS  = 8;
  localparam int ROUNDS      = 64;
  localparam int LEN_POS     = 56;
  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam logic [31:0] START_H [HASH_WORDS] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // control from the sequencer to the compression unit
  typedef struct packed {
    logic start;
    logic reload;
  } core_ctl_t;

  // status of the compression unit
  typedef struct packed {
    logic busy;
    logic done;
  } core_sts_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_sig0(input logic [31:0] x);
    big_sig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_sig1(input logic [31:0] x);
    big_sig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] small_sig0(input logic [31:0] x);
    small_sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sig1(input logic [31:0] x);
    small_sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] choose(input logic [31:0] e, input logic [31:0] f,
                                         input logic [31:0] g);
    choose = (e & f) ^ (~e & g);
  endfunction

  function automatic logic [31:0] majority(input logic [31:0] a, input logic [31:0] b,
                                           input logic [31:0] c);
    majority = (a & b) ^ (a & c) ^ (b & c);
  endfunction

endpackage

`default_nettype wire

### design/sha256s_core.sv
// sha-256 compression unit: one round per cycle over a shifting schedule window
`default_nettype none

module sha256s_core (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire sha256s_pkg::core_ctl_t ctl,
  input  wire logic [31:0]            blk_words [sha256s_pkg::BLOCK_WORDS],
  output sha256s_pkg::core_sts_t      sts,
  output logic [31:0]                 hash_words [sha256s_pkg::HASH_WORDS]
);

  typedef enum logic [2:0] {
    C_IDLE   = 3'b001,
    C_ROUND  = 3'b010,
    C_UPDATE = 3'b100
  } c_state_t;

  localparam logic [5:0] LAST_ROUND = 6'(sha256s_pkg::ROUNDS - 1);

  c_state_t    state_r, state_nxt;
  logic [5:0]  rnd_r, rnd_nxt;
  logic [31:0] hash_r [sha256s_pkg::HASH_WORDS];
  logic [31:0] hash_nxt [sha256s_pkg::HASH_WORDS];
  logic [31:0] var_r [sha256s_pkg::HASH_WORDS];
  logic [31:0] var_nxt [sha256s_pkg::HASH_WORDS];
  logic [31:0] win_r [sha256s_pkg::BLOCK_WORDS];
  logic [31:0] win_nxt [sha256s_pkg::BLOCK_WORDS];
  logic [31:0] t1, t2, w_new;

  // round arithmetic and next schedule word
  always_comb begin
    t1 = var_r[7] + sha256s_pkg::big_sig1(var_r[4])
       + sha256s_pkg::choose(var_r[4], var_r[5], var_r[6])
       + sha256s_pkg::ROUND_K[rnd_r] + win_r[0];
    t2 = sha256s_pkg::big_sig0(var_r[0])
       + sha256s_pkg::majority(var_r[0], var_r[1], var_r[2]);
    w_new = sha256s_pkg::small_sig1(win_r[14]) + win_r[9]
          + sha256s_pkg::small_sig0(win_r[1]) + win_r[0];
  end

  // sequencer and register updates
  always_comb begin
    state_nxt = state_r;
    rnd_nxt   = rnd_r;
    hash_nxt  = hash_r;
    var_nxt   = var_r;
    win_nxt   = win_r;
    case (state_r)
      C_IDLE: begin
        if (ctl.reload) begin
          hash_nxt = sha256s_pkg::START_H;
        end
        if (ctl.start) begin
          var_nxt   = hash_r;
          win_nxt   = blk_words;
          rnd_nxt   = '0;
          state_nxt = C_ROUND;
        end
      end
      C_ROUND: begin
        for (int k = 0; k < sha256s_pkg::BLOCK_WORDS - 1; k++) begin
          win_nxt[k] = win_r[k + 1];
        end
        win_nxt[sha256s_pkg::BLOCK_WORDS - 1] = w_new;
        for (int k = 1; k < sha256s_pkg::HASH_WORDS; k++) begin
          var_nxt[k] = var_r[k - 1];
        end
        var_nxt[4] = var_r[3] + t1;
        var_nxt[0] = t1 + t2;
        rnd_nxt    = rnd_r + 6'd1;
        if (rnd_r == LAST_ROUND) begin
          state_nxt = C_UPDATE;
        end
      end
      C_UPDATE: begin
        for (int k = 0; k < sha256s_pkg::HASH_WORDS; k++) begin
          hash_nxt[k] = hash_r[k] + var_r[k];
        end
        state_nxt = C_IDLE;
      end
      default: begin
        state_nxt = C_IDLE;
      end
    endcase
  end

  // control state and chaining value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      rnd_r   <= '0;
      hash_r  <= sha256s_pkg::START_H;
    end else begin
      state_r <= state_nxt;
      rnd_r   <= rnd_nxt;
      hash_r  <= hash_nxt;
    end
  end

  // working variables and schedule window
  always_ff @(posedge clk) begin
    var_r <= var_nxt;
    win_r <= win_nxt;
  end

  assign sts.busy   = (state_r != C_IDLE);
  assign sts.done   = (state_r == C_UPDATE);
  assign hash_words = hash_r;

endmodule

`default_nettype wire

### design/sha256_stream_hash.sv
// sha256_stream_hash: top level of a streaming sha-256 hasher. A request carries a big-endian
// word with 0 to 4 leading message bytes; the last request closes the message and is answered
// by eight digest word requests, index 0 first. Each input word is accepted first, then its
// bytes are placed into the 64-byte block buffer; no new word is taken meanwhile. Every 64th
// byte starts a compression on the single shared round unit: a start, the rounds and one
// chaining update. The last word adds a padding step and one compression; when more than 55
// bytes of the final block are in use it adds a padding step, a compression, a length block
// step and a second compression before the digest is shown. The block takes no new word until
// the eighth digest word is taken.
`default_nettype none

`include "sha256_stream_hash_assert.svh"

module sha256_stream_hash (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] in_data_word,
  input  wire logic [2:0]  in_byte_count,
  input  wire logic        in_last_item,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_digest_word,
  output logic [2:0]       out_word_index,
  output logic             out_last_word
);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b00000001,
    S_INSERT   = 8'b00000010,
    S_WAIT_INS = 8'b00000100,
    S_PAD      = 8'b00001000,
    S_WAIT_PAD = 8'b00010000,
    S_LEN      = 8'b00100000,
    S_WAIT_FIN = 8'b01000000,
    S_OUT      = 8'b10000000
  } st_t;

  localparam logic [2:0] MAX_BYTES = 3'(sha256s_pkg::WORD_BYTES);
  localparam logic [2:0] LAST_IDX  = 3'(sha256s_pkg::HASH_WORDS - 1);
  localparam logic [5:0] LEN_START = 6'(sha256s_pkg::LEN_POS);

  st_t         state_r, state_nxt;
  logic [31:0] word_r, word_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [2:0]  skip_r, skip_nxt;
  logic        last_r, last_nxt;
  logic [63:0] total_r, total_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic        start_r, start_nxt;
  logic        reload;
  logic [7:0]  blk_r [sha256s_pkg::BLOCK_BYTES];
  logic [7:0]  blk_nxt [sha256s_pkg::BLOCK_BYTES];

  logic [5:0]  base;
  logic [2:0]  avail;
  logic [6:0]  room;
  logic        fill;
  logic [2:0]  wr;
  logic        short_pad;
  logic [63:0] bits;
  logic [7:0]  wb [sha256s_pkg::WORD_BYTES];
  logic [7:0]  bits_b [8];
  logic        last_taken;

  sha256s_pkg::core_ctl_t core_ctl;
  sha256s_pkg::core_sts_t core_sts;
  logic [31:0]            blk_words [sha256s_pkg::BLOCK_WORDS];
  logic [31:0]            hash_words [sha256s_pkg::HASH_WORDS];

  // fill level, room left in the block and bytes placed this cycle
  always_comb begin
    base      = total_r[5:0];
    avail     = cnt_r - skip_r;
    room      = 7'(sha256s_pkg::BLOCK_BYTES) - {1'b0, base};
    fill      = ({4'b0000, avail} >= room);
    wr        = fill ? room[2:0] : avail;
    short_pad = (base < LEN_START);
    bits      = {total_r[60:0], 3'b000};
    for (int k = 0; k < sha256s_pkg::WORD_BYTES; k++) begin
      wb[k] = word_r[31 - 8 * k -: 8];
    end
    for (int k = 0; k < 8; k++) begin
      bits_b[k] = bits[63 - 8 * k -: 8];
    end
  end

  // sequencer: byte placement, padding, length block and digest readout
  always_comb begin
    logic [5:0] d;
    d         = '0;
    state_nxt = state_r;
    word_nxt  = word_r;
    cnt_nxt   = cnt_r;
    skip_nxt  = skip_r;
    last_nxt  = last_r;
    total_nxt = total_r;
    idx_nxt   = idx_r;
    start_nxt = 1'b0;
    reload    = 1'b0;
    blk_nxt   = blk_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          word_nxt  = in_data_word;
          cnt_nxt   = (in_byte_count > MAX_BYTES) ? MAX_BYTES : in_byte_count;
          skip_nxt  = '0;
          last_nxt  = in_last_item;
          state_nxt = S_INSERT;
        end
      end
      S_INSERT: begin
        for (int j = 0; j < sha256s_pkg::BLOCK_BYTES; j++) begin
          d = 6'(j) - base;
          if (d < {3'b000, wr}) begin
            blk_nxt[j] = wb[skip_r[1:0] + d[1:0]];
          end
        end
        total_nxt = total_r + 64'(wr);
        if (fill) begin
          start_nxt = 1'b1;
          skip_nxt  = skip_r + wr;
          state_nxt = S_WAIT_INS;
        end else begin
          state_nxt = last_r ? S_PAD : S_IDLE;
        end
      end
      S_WAIT_INS: begin
        if (core_sts.done) begin
          state_nxt = S_INSERT;
        end
      end
      S_PAD: begin
        for (int j = 0; j < sha256s_pkg::BLOCK_BYTES; j++) begin
          if (6'(j) == base) begin
            blk_nxt[j] = sha256s_pkg::PAD_BYTE;
          end else if (6'(j) > base) begin
            blk_nxt[j] = '0;
          end
          if (short_pad && (j >= sha256s_pkg::LEN_POS)) begin
            blk_nxt[j] = bits_b[3'(j)];
          end
        end
        start_nxt = 1'b1;
        state_nxt = short_pad ? S_WAIT_FIN : S_WAIT_PAD;
      end
      S_WAIT_PAD: begin
        if (core_sts.done) begin
          state_nxt = S_LEN;
        end
      end
      S_LEN: begin
        for (int j = 0; j < sha256s_pkg::BLOCK_BYTES; j++) begin
          blk_nxt[j] = (j >= sha256s_pkg::LEN_POS) ? bits_b[3'(j)] : 8'h00;
        end
        start_nxt = 1'b1;
        state_nxt = S_WAIT_FIN;
      end
      S_WAIT_FIN: begin
        if (core_sts.done) begin
          idx_nxt   = '0;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_stall) begin
          idx_nxt = idx_r + 3'd1;
          if (idx_r == LAST_IDX) begin
            reload    = 1'b1;
            total_nxt = '0;
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      total_r <= '0;
      idx_r   <= '0;
      start_r <= 1'b0;
      skip_r  <= '0;
      cnt_r   <= '0;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      total_r <= total_nxt;
      idx_r   <= idx_nxt;
      start_r <= start_nxt;
      skip_r  <= skip_nxt;
      cnt_r   <= cnt_nxt;
      last_r  <= last_nxt;
    end
  end

  // held word and block buffer
  always_ff @(posedge clk) begin
    word_r <= word_nxt;
    blk_r  <= blk_nxt;
  end

  // block buffer as big-endian words for the round unit
  always_comb begin
    for (int k = 0; k < sha256s_pkg::BLOCK_WORDS; k++) begin
      blk_words[k] = {blk_r[4 * k], blk_r[4 * k + 1], blk_r[4 * k + 2], blk_r[4 * k + 3]};
    end
  end

  // compression start is registered together with the buffer, so the round unit sees it with the settled block
  always_comb begin
    core_ctl.start  = start_r;
    core_ctl.reload = reload;
  end

  sha256s_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (core_ctl),
    .blk_words  (blk_words),
    .sts        (core_sts),
    .hash_words (hash_words)
  );

  // handshake and digest outputs
  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = (state_r == S_OUT);
  assign out_digest_word = hash_words[idx_r];
  assign out_word_index  = idx_r;
  assign out_last_word   = (idx_r == LAST_IDX);
  assign last_taken      = out_valid && !out_stall && out_last_word;

  // checks on sequencing between the buffer side and the round unit
  `SHS_ASSERT_NOW(a_out_core_quiet, out_valid, !core_sts.busy, "digest shown during compression")
  `SHS_ASSERT_NOW(a_ready_core_quiet, !in_stall, !core_sts.busy, "request taken in compression")
  `SHS_ASSERT_NEXT(a_ready_after_digest, last_taken, !in_stall, "not ready after digest")
  `SHS_ASSERT_NEXT(a_count_cleared, last_taken, total_r == 64'd0, "byte count kept after digest")

endmodule

`default_nettype wire
